// ===== hdl/bba_pkg.sv =====
`default_nettype none
package bba_pkg;

  // Bitmap geometry. WORD_BITS is a power of two; MAX_BLOCKS a multiple of it.
  localparam int MAX_BLOCKS = 1024;
  localparam int WORD_BITS  = 32;
  localparam int NWORDS     = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WSEL_W     = (NWORDS > 1) ? $clog2(NWORDS) : 1;

  // Field widths
  localparam int BLK_W = 16;
  localparam int CNT_W = 11;
  localparam int POS_W = BLK_W + 1;  // unwrapped block arithmetic

  localparam logic [7:0] TAIL_MASK = 8'hff;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_DOUBLE = 2'd3
  } status_t;

  typedef enum logic {
    FN_ALLOC = 1'b0,
    FN_FREE  = 1'b1
  } func_t;

  typedef enum logic {
    CFG_DATA_BASE  = 1'b0,
    CFG_DATA_COUNT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    RD_ZERO = 2'd0,
    RD_NEXT = 2'd1,
    RD_FREE = 2'd2
  } rd_sel_t;

  typedef enum logic [2:0] {
    S_IDLE        = 3'd0,
    S_ALLOC_START = 3'd1,
    S_SCAN        = 3'd2,
    S_FREE        = 3'd3,
    S_FREE_CHK    = 3'd4,
    S_EMIT        = 3'd5
  } state_t;

  typedef struct packed {
    logic    load;      // capture input transfer
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_alloc;  // set found bit in current word
    logic    wr_free;   // clear requested bit in current word
    logic    res_load;
    status_t res_code;
    logic    emit;      // pending result -> output register
  } cmd_t;

  typedef struct packed {
    logic func_free;
    logic in_range;
    logic hit;
    logic bit_set;
    logic last_word;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/block_bitmap_allocator.sv =====
// Channel  Direction  Handshake               Payload
// in       slave      in_tvalid / in_tready   tuser: func; tdata: block_in
// out      master     out_tvalid / out_tready tuser: status; tdata: block_out
// cfg      slave      cfg_valid / cfg_ready   cfg_index, cfg_data (always ready)
//
// Allocate: decode, read of word 0, then one bitmap word at a time until a
// free bit or the last word; the single-port bitmap read is the limit.
// Free: range check and word read, bit check and write, emit; an out-of-range
// free skips the bit check. The next transfer in is taken once back in idle.
// Reset (rst_n, synchronous) sets the config to base 0, count 1024 and clears
// the word valid bits, so the whole bitmap reads free at once; no clearing pass.
// A result waiting in the output register does not stop the next transfer
// in; the block stalls only when a second result is ready before the first
// has been taken.
`default_nettype none
module block_bitmap_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] block_in
  input  wire logic [0:0]  in_tuser,   // [0] func
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] block_out
  output logic [1:0]       out_tuser,  // [1:0] status
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,  // 0 data_base, 1 data_count
  input  wire logic [15:0] cfg_data
);
  import bba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // config writes are never back-pressured
  assign cfg_ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  bba_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_func    (in_tuser[0]),
    .in_block   (in_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_status (out_tuser),
    .out_block  (out_tdata)
  );

endmodule
`default_nettype wire

// ===== hdl/bba_ctrl.sv =====
`default_nettype none
module bba_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  input  wire bba_pkg::sts_t sts,
  output bba_pkg::cmd_t     cmd
);
  import bba_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_FREE;
      end
      S_FREE: begin
        if (!sts.func_free)    state_nxt = S_ALLOC_START;
        else if (sts.in_range) state_nxt = S_FREE_CHK;
        else                   state_nxt = S_EMIT;
      end
      S_FREE_CHK:    state_nxt = S_EMIT;
      S_ALLOC_START: state_nxt = S_SCAN;
      S_SCAN: begin
        if (sts.hit || sts.last_word) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.rd_sel   = RD_ZERO;
    cmd.res_code = ST_OK;
    case (state_r)
      S_IDLE: cmd.load = in_tvalid;
      S_FREE: begin
        // decode step; range failure finishes here
        if (sts.func_free) begin
          if (sts.in_range) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_FREE;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_code = ST_RANGE;
          end
        end
      end
      S_FREE_CHK: begin
        cmd.res_load = 1'b1;
        if (sts.bit_set) begin
          cmd.wr_free  = 1'b1;
          cmd.res_code = ST_OK;
        end else begin
          cmd.res_code = ST_DOUBLE;
        end
      end
      S_ALLOC_START: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_ZERO;
      end
      S_SCAN: begin
        if (sts.hit) begin
          cmd.wr_alloc = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_code = ST_OK;
        end else if (sts.last_word) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_FULL;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
        end
      end
      S_EMIT: cmd.emit = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit)      out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bba_dp.sv =====
`default_nettype none
module bba_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_func,
  input  wire logic [bba_pkg::BLK_W-1:0]     in_block,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [bba_pkg::BLK_W-1:0]     cfg_data,
  input  wire bba_pkg::cmd_t                 cmd,
  output bba_pkg::sts_t                      sts,
  output logic [1:0]                         out_status,
  output logic [bba_pkg::BLK_W-1:0]          out_block
);
  import bba_pkg::*;

  // config registers
  logic [BLK_W-1:0] data_base_r;
  logic [CNT_W-1:0] data_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_base_r  <= '0;
      data_count_r <= CNT_W'(1024);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DATA_BASE:  data_base_r  <= cfg_data;
        CFG_DATA_COUNT: data_count_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective count and allocate limit (count rounded down to 8)
  logic [POS_W-1:0] cnt_ext, eff_cnt, limit, base_ext;
  assign cnt_ext  = POS_W'(data_count_r);
  assign eff_cnt  = (cnt_ext > POS_W'(MAX_BLOCKS)) ? POS_W'(MAX_BLOCKS) : cnt_ext;
  assign limit    = eff_cnt & ~POS_W'(TAIL_MASK >> 5);
  assign base_ext = POS_W'(data_base_r);

  // captured request
  logic             func_r;
  logic [BLK_W-1:0] blk_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      blk_r  <= in_block;
    end
  end

  logic [POS_W-1:0]  blk_ext, free_idx;
  logic [WSEL_W-1:0] free_word;
  logic [BIT_W-1:0]  free_bit;
  assign blk_ext   = POS_W'(blk_r);
  assign free_idx  = blk_ext - base_ext;
  assign free_word = free_idx[BIT_W +: WSEL_W];
  assign free_bit  = free_idx[BIT_W-1:0];

  // bitmap store with per-word valid bits (invalid word reads as all free)
  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [NWORDS-1:0]    word_vld_r;
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_vld_r;
  logic [WSEL_W-1:0]    word_r, rd_addr;
  logic [WORD_BITS-1:0] cur_word, wr_word, free_m;
  logic [BIT_W-1:0]     found_bit;
  logic                 wr_en;

  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO: rd_addr = '0;
      RD_NEXT: rd_addr = word_r + WSEL_W'(1);
      RD_FREE: rd_addr = free_word;
      default: rd_addr = '0;
    endcase
  end

  assign cur_word = rd_vld_r ? rd_data_r : '0;
  assign wr_en    = cmd.wr_alloc || cmd.wr_free;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      free_m[b] = !cur_word[b] &&
                  (POS_W'({word_r, BIT_W'(b)}) < limit);
    end
  end

  always_comb begin
    found_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_m[b]) found_bit = BIT_W'(b);
    end
  end

  always_comb begin
    if (cmd.wr_alloc) wr_word = cur_word | (WORD_BITS'(1) << found_bit);
    else              wr_word = cur_word & ~(WORD_BITS'(1) << free_bit);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[word_r] <= wr_word;
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
      word_r    <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_vld_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      if (wr_en)     word_vld_r[word_r] <= 1'b1;
      if (cmd.rd_en) rd_vld_r <= word_vld_r[rd_addr];
    end
  end

  // status to controller
  assign sts.func_free = (func_t'(func_r) == FN_FREE);
  assign sts.in_range  = !(blk_ext < base_ext) && (blk_ext < base_ext + eff_cnt);
  assign sts.hit       = |free_m;
  assign sts.bit_set   = cur_word[free_bit];
  assign sts.last_word = (word_r == WSEL_W'(NWORDS - 1));

  // pending result, then output register
  logic [BLK_W-1:0] found_blk;
  status_t          pend_status_r;
  logic [BLK_W-1:0] pend_block_r;
  logic [1:0]       out_status_r;
  logic [BLK_W-1:0] out_block_r;

  assign found_blk = BLK_W'(base_ext + POS_W'({word_r, found_bit}));

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      pend_status_r <= cmd.res_code;
      pend_block_r  <= cmd.wr_alloc ? found_blk : '0;
    end
    if (cmd.emit) begin
      out_status_r <= pend_status_r;
      out_block_r  <= pend_block_r;
    end
  end

  assign out_status = out_status_r;
  assign out_block  = out_block_r;

endmodule
`default_nettype wire

// ===== sim/block_bitmap_allocator_tb.sv =====
module block_bitmap_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  // Cycles to let pass once the last result is in, before a register write
  // or the verdict. Covers a full scan of the bitmap plus margin.
  localparam int SETTLE_CYCLES = NWORDS + 8;
  // Cycles without any transfer on any channel before the run is declared hung.
  localparam int HANG_LIMIT    = 2000;
  localparam int RANDOM_PHASES = 13;
  localparam int PHASE_ITEMS   = 107;

  // One request on the input stream.
  typedef struct {
    func_t            fn;
    logic [BLK_W-1:0] blk;
  } request_t;

  // One result on the output stream.
  typedef struct {
    status_t          status;
    logic [BLK_W-1:0] block;
  } outcome_t;

  typedef struct {
    cfg_idx_t         idx;
    logic [BLK_W-1:0] value;
  } reg_write_t;

  // Used/free map plus the two registers, as the block sees them.
  typedef struct {
    logic [MAX_BLOCKS-1:0] used;
    logic [BLK_W-1:0]      base;
    logic [CNT_W-1:0]      count;
  } block_map_t;

  logic clk;
  logic rst_n = 1'b0;

  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [15:0]      in_tdata   = '0;
  logic [0:0]       in_tuser   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [15:0]      out_tdata;
  logic [1:0]       out_tuser;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic             cfg_index  = 1'b0;
  logic [15:0]      cfg_data   = '0;

  block_bitmap_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [15:0] block_in
    .in_tuser   (in_tuser),    // [0] func
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [15:0] block_out
    .out_tuser  (out_tuser),   // [1:0] status
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // tracked_map follows the block transfer by transfer (checking side);
  // planned_map follows the generated sequence so frees can target used blocks.
  block_map_t tracked_map;
  block_map_t planned_map;

  request_t   request_queue[$];
  reg_write_t reg_write_queue[$];
  outcome_t   expected_results[$];

  int  errors     = 0;
  int  idle_count = 0;
  int  n_alloc    = 0;
  int  n_free     = 0;
  int  n_checked  = 0;
  int  n_reg_wr   = 0;
  int  status_hits[4] = '{0, 0, 0, 0};
  bit  quiet      = 1'b0;   // no gaps, no stalls

  // Sender burst/gap state and receiver stall state (driver-private).
  int  burst_left = 0;
  int  gap_left   = 0;
  int  ready_left = 0;

  function automatic void clear_map(output block_map_t st);
    st.used  = '0;
    st.base  = '0;
    st.count = 11'd1024;
  endfunction

  function automatic void set_register(inout block_map_t st, input cfg_idx_t idx,
                                       input logic [BLK_W-1:0] value);
    if (idx == CFG_DATA_BASE) begin
      st.base = value;
    end else begin
      st.count = value[CNT_W-1:0];
    end
  endfunction

  function automatic int usable_count(block_map_t st);
    return (int'(st.count) > MAX_BLOCKS) ? MAX_BLOCKS : int'(st.count);
  endfunction

  // First-fit allocate or checked free; updates the map and returns the result.
  function automatic outcome_t serve_request(inout block_map_t st, input func_t fn,
                                             input logic [BLK_W-1:0] blk);
    outcome_t res;
    int       cnt;
    int       lim;
    int       idx;
    int       sum;
    bit       found;
    res.status = ST_FULL;
    res.block  = '0;
    cnt        = usable_count(st);
    found      = 1'b0;
    if (fn == FN_ALLOC) begin
      // only whole groups of eight are handed out; the tail stays reserved
      lim = (cnt / 8) * 8;
      for (idx = 0; idx < lim; idx++) begin
        if (!found && !st.used[idx]) begin
          found         = 1'b1;
          st.used[idx]  = 1'b1;
          sum           = int'(st.base) + idx;
          res.block     = sum[BLK_W-1:0];   // may wrap past 65535
          res.status    = ST_OK;
        end
      end
    end else begin
      // unwrapped range compare: a wrapped block number is never in range
      if (int'(blk) < int'(st.base) || int'(blk) >= int'(st.base) + cnt) begin
        res.status = ST_RANGE;
      end else begin
        idx = int'(blk) - int'(st.base);
        if (!st.used[idx]) begin
          res.status = ST_DOUBLE;
        end else begin
          st.used[idx] = 1'b0;
          res.status   = ST_OK;
        end
      end
    end
    return res;
  endfunction

  // Block number of some used block in range, scanning from a random start (any block in range if none is used).
  function automatic logic [BLK_W-1:0] pick_used(block_map_t st);
    int cnt;
    int start;
    int k;
    int i;
    int hit;
    cnt = usable_count(st);
    if (cnt == 0) begin
      return st.base;
    end
    start = $urandom_range(0, cnt - 1);
    hit   = start;
    for (k = cnt - 1; k >= 0; k--) begin
      i = (start + k) % cnt;
      if (st.used[i]) begin
        hit = i;
      end
    end
    i = int'(st.base) + hit;
    return i[BLK_W-1:0];
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Input driver: bursts of random length, random gaps between them.
  // valid is held until the transfer completes.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        request_queue.delete(0);
      end
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= request_queue[0].blk;
          in_tuser  <= request_queue[0].fn;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: ready runs and stall runs of random length,
  // now and then a long stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (ready_left > 0) begin
      ready_left--;
    end else if (quiet || $urandom_range(0, 2) != 0) begin
      out_tready <= 1'b1;
      ready_left = $urandom_range(0, 20);
    end else begin
      out_tready <= 1'b0;
      ready_left = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 4);
    end
  end

  // Register write driver, fed by reg_write_queue.
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        reg_write_queue.delete(0);
      end
      if (!(cfg_valid && !cfg_ready)) begin
        if (reg_write_queue.size() > 0) begin
          cfg_valid <= 1'b1;
          cfg_index <= reg_write_queue[0].idx;
          cfg_data  <= reg_write_queue[0].value;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: tracks register writes, predicts each accepted request,
  // checks each accepted result against the oldest prediction. Also the
  // hang watchdog.
  always @(posedge clk) begin
    bit       moved;
    outcome_t want;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        n_reg_wr++;
        set_register(tracked_map, cfg_idx_t'(cfg_index), cfg_data);
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          $error("result with no request pending: status=%0d block_out=%0d",
                 out_tuser, out_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          status_hits[want.status]++;
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            errors++;
          end
          if (out_tdata !== want.block) begin
            $error("block_out: expected %0d, got %0d", want.block, out_tdata);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        if (in_tuser[0] == FN_ALLOC) n_alloc++;
        else n_free++;
        expected_results.push_back(serve_request(tracked_map, func_t'(in_tuser[0]), in_tdata));
      end
      idle_count = moved ? 0 : idle_count + 1;
      if (idle_count >= HANG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 HANG_LIMIT, expected_results.size());
        $display("** block_bitmap_allocator: FAILED **");
        $finish;
      end
    end
  end

  // Queue a request; planned_map follows so later frees can aim at used blocks.
  task automatic push_request(func_t fn, logic [BLK_W-1:0] blk);
    request_t req;
    outcome_t unused;
    req.fn  = fn;
    req.blk = blk;
    request_queue.push_back(req);
    unused = serve_request(planned_map, fn, blk);
  endtask

  // Queue a register write and wait until it has landed, so no request
  // ever runs across a register change.
  task automatic write_reg(cfg_idx_t idx, logic [BLK_W-1:0] value);
    reg_write_t wr;
    wr.idx   = idx;
    wr.value = value;
    reg_write_queue.push_back(wr);
    set_register(planned_map, idx, value);
    do @(posedge clk);
    while (reg_write_queue.size() != 0 || cfg_valid);
  endtask

  // Sender pauses here until every outstanding result is in and the block
  // has had time to go idle.
  task automatic wait_drained();
    do @(posedge clk);
    while (request_queue.size() != 0 || in_tvalid || expected_results.size() != 0 ||
           reg_write_queue.size() != 0 || cfg_valid);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed traffic: allocates and frees of used blocks, plus
  // noise (random numbers, range edges, double frees).
  task automatic push_random();
    int               r;
    int               cnt;
    int               v;
    logic [BLK_W-1:0] blk;
    r   = $urandom_range(0, 99);
    cnt = usable_count(planned_map);
    if (r < 55) begin
      push_request(FN_ALLOC, BLK_W'($urandom_range(0, 65535)));
    end else if (r < 88) begin
      push_request(FN_FREE, pick_used(planned_map));
    end else if (r < 93) begin
      push_request(FN_FREE, BLK_W'($urandom_range(0, 65535)));
    end else if (r < 97) begin
      case ($urandom_range(0, 3))
        0:       v = int'(planned_map.base) - 1;
        1:       v = int'(planned_map.base) + cnt;
        2:       v = int'(planned_map.base) + cnt - 1;
        default: v = int'(planned_map.base);
      endcase
      blk = v[BLK_W-1:0];
      push_request(FN_FREE, blk);
    end else begin
      v   = int'(planned_map.base) + $urandom_range(0, cnt + 8);
      blk = v[BLK_W-1:0];
      push_request(FN_FREE, blk);
    end
  endtask

  // Stimulus
  initial begin
    int               p;
    int               n;
    int               r;
    int               cnt;
    logic [BLK_W-1:0] base_val;
    logic [BLK_W-1:0] count_val;

    clear_map(tracked_map);
    clear_map(planned_map);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // Reset settings: base 0, 1024 blocks. Block zero comes out with ok
    // status; free of a clear bit, frees beyond the range.
    push_request(FN_ALLOC, 16'hffff);
    push_request(FN_ALLOC, 16'h0000);
    push_request(FN_ALLOC, 16'h5a5a);
    push_request(FN_FREE,  16'd0);
    push_request(FN_FREE,  16'd0);       // double free
    push_request(FN_FREE,  16'd1024);    // one past the end
    push_request(FN_FREE,  16'hffff);
    push_request(FN_ALLOC, 16'h0000);    // block zero again
    for (n = 0; n < 8; n++) begin
      push_request(FN_ALLOC, 16'h0000);  // fills indices up to 10
    end
    wait_drained();

    // 13 blocks (upper data bits are dropped): indices 8..12 are tail.
    // Tail bits set earlier can still be freed; allocate finds nothing.
    write_reg(CFG_DATA_COUNT, 16'hf80d);
    push_request(FN_FREE,  16'd10);
    push_request(FN_FREE,  16'd12);
    push_request(FN_FREE,  16'd13);
    push_request(FN_ALLOC, 16'h0000);
    wait_drained();

    // Fewer than eight blocks, then none at all.
    write_reg(CFG_DATA_COUNT, 16'd5);
    push_request(FN_ALLOC, 16'h0000);
    wait_drained();
    write_reg(CFG_DATA_COUNT, 16'd0);
    push_request(FN_FREE,  16'd0);
    push_request(FN_ALLOC, 16'h0000);
    wait_drained();

    // Count above capacity acts as full size; base near the top so the
    // allocated numbers wrap, and the wrapped number cannot be freed.
    write_reg(CFG_DATA_BASE,  16'hfff8);
    write_reg(CFG_DATA_COUNT, 16'h07ff);
    push_request(FN_ALLOC, 16'h0000);
    push_request(FN_FREE,  16'd2);
    push_request(FN_FREE,  16'hffff);
    push_request(FN_ALLOC, 16'h0000);
    wait_drained();

    // Random phases, each with its own register settings.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      r = $urandom_range(0, 9);
      if (r < 3)      base_val = 16'h0000;
      else if (r < 5) base_val = BLK_W'($urandom_range(0, 65535));
      else if (r < 7) base_val = 16'hffff - BLK_W'($urandom_range(0, 40));
      else            base_val = BLK_W'($urandom_range(0, 2000));
      r = $urandom_range(0, 9);
      if (r < 6)       cnt = $urandom_range(8, 64);
      else if (r == 6) cnt = MAX_BLOCKS;
      else if (r == 7) cnt = 2047;
      else if (r == 8) cnt = $urandom_range(0, 2047);
      else             cnt = $urandom_range(0, 7);
      count_val = {5'($urandom_range(0, 31)), cnt[CNT_W-1:0]};
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_DATA_BASE, base_val);
        write_reg(CFG_DATA_COUNT, count_val);
      end else begin
        write_reg(CFG_DATA_COUNT, count_val);
        write_reg(CFG_DATA_BASE, base_val);
      end
      quiet = (p % 4 == 3);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        push_random();
      end
      wait_drained();
    end
    quiet = 1'b0;

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end
    $display("covered %0d requests (%0d allocate, %0d free) and %0d register writes",
             n_alloc + n_free, n_alloc, n_free, n_reg_wr);
    $display("checked %0d results: ok %0d, no free %0d, out of range %0d, double free %0d",
             n_checked, status_hits[ST_OK], status_hits[ST_FULL],
             status_hits[ST_RANGE], status_hits[ST_DOUBLE]);
    if (errors == 0) begin
      $display("** block_bitmap_allocator: PASSED **");
    end else begin
      $display("** block_bitmap_allocator: FAILED **");
    end
    $finish;
  end

endmodule
